// File: rtl/mbps_pkg.sv
// Shared types and constants of the masked byte pattern search block.
// No dependencies; every module of the block imports this package.
package mbps_pkg;

  // Largest pattern the register map can describe, and the default build size.
  localparam int MAX_PATTERN_BYTES = 16;
  localparam int PATTERN_BYTES_DEF = 16;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CARE_MASK    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LEN  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_WANTED_OCC   = 3'd4;

  // Register reset values.
  localparam logic [63:0] PATTERN_RST   = 64'h0;
  localparam logic [15:0] CARE_MASK_RST = 16'hFFFF;
  localparam logic [4:0]  PAT_LEN_RST   = 5'd16;
  localparam logic [15:0] WANTED_RST    = 16'h0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       region_first;
    logic       region_last;
  } in_word_t;

  typedef struct packed {
    logic        match_found;
    logic [31:0] match_offset;
  } out_word_t;

endpackage

// File: rtl/masked_byte_pattern_search.sv
// Top level of the masked byte pattern search block.
// Depends on mbps_pkg and mbps_window_cmp.
//
// Scans a byte stream, one data word per clock, for a pattern of up to
// PATTERN_BYTES bytes with a per-byte care mask (byte 0 is always compared).
// Matches are counted from zero at each word flagged region_first; when the
// count reaches wanted_occurrence one word is returned with match_found set
// and the offset of the match start, and the rest of the region is dropped.
// If the region_last word passes without that, a not-found word (offset 0)
// is returned. Every start offset where the whole pattern fits is tried,
// overlapping matches included. Throughput is one input word per clock,
// sustained as long as out_ready stays high. The accepting edge loads the
// input stage; compare and decision load the result into the output
// register as that word leaves the input stage. Only a result word held
// by out_ready low, with a word waiting in the input stage, stops in_ready.
// Configuration writes are taken in any cycle (cfg_ready is always high) and
// must only be issued while the block is idle. Offsets saturate at
// 32'hFFFFFFFF for very long regions; the match count saturates at 16'hFFFF.
module masked_byte_pattern_search import mbps_pkg::*; #(
  parameter int PATTERN_BYTES = PATTERN_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_word_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_word_t              out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int LW = $clog2(PATTERN_BYTES + 1);

  // Configuration registers.
  logic [63:0] pat_low_r, pat_high_r;
  logic [15:0] care_mask_r, wanted_r;
  logic [4:0]  pat_len_r;
  logic [LW-1:0] used_len;

  // Input stage: window and byte position of the word under test.
  logic [PATTERN_BYTES-1:0][7:0] win_r, win_nxt;
  logic [31:0] seen_r, seen_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic        s1_valid_r, s1_valid_nxt;
  logic        s1_first_r, s1_last_r;

  // Decision stage state.
  logic [15:0] cnt_r, cnt_nxt, cnt_eff;
  logic        done_r, done_nxt, done_eff;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  out_word_t   out_data_r, out_data_nxt;

  logic in_accept, stall, s1_adv, hit, fits, produce;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r   <= PATTERN_RST;
      pat_high_r  <= PATTERN_RST;
      care_mask_r <= CARE_MASK_RST;
      pat_len_r   <= PAT_LEN_RST;
      wanted_r    <= WANTED_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PATTERN_LOW:  pat_low_r   <= cfg_data;
        CFG_PATTERN_HIGH: pat_high_r  <= cfg_data;
        CFG_CARE_MASK:    care_mask_r <= cfg_data[15:0];
        CFG_PATTERN_LEN:  pat_len_r   <= cfg_data[4:0];
        CFG_WANTED_OCC:   wanted_r    <= cfg_data[15:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // Clamp the programmed length into 1 .. PATTERN_BYTES.
  always_comb begin
    priority if (pat_len_r == 5'd0) begin
      used_len = LW'(1);
    end else if (pat_len_r > 5'(PATTERN_BYTES)) begin
      used_len = LW'(PATTERN_BYTES);
    end else begin
      used_len = LW'(pat_len_r);
    end
  end

  // Handshake: hold the input stage only while a result word is stuck.
  assign stall     = out_valid_r && !out_ready;
  assign s1_adv    = s1_valid_r && !stall;
  assign in_ready  = !s1_valid_r || !stall;
  assign in_accept = in_valid && in_ready;

  // Input stage. Words after a result still shift the window; that is
  // harmless because only a region start makes the block look again, and a
  // region start clears the window and the position.
  always_comb begin
    logic [PATTERN_BYTES-1:0][7:0] base;
    base         = in_data.region_first ? '0 : win_r;
    pos_nxt      = in_data.region_first ? '0 : seen_r;
    seen_nxt     = (pos_nxt == '1) ? pos_nxt : pos_nxt + 32'd1;
    win_nxt      = {base[PATTERN_BYTES-2:0], in_data.data_byte};
    s1_valid_nxt = in_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      seen_r     <= '0;
      win_r      <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (in_accept) begin
        seen_r <= seen_nxt;
        win_r  <= win_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      pos_r      <= pos_nxt;
      s1_first_r <= in_data.region_first;
      s1_last_r  <= in_data.region_last;
    end
  end

  mbps_window_cmp #(
    .PATTERN_BYTES(PATTERN_BYTES)
  ) u_cmp (
    .window   (win_r),
    .pat_low  (pat_low_r),
    .pat_high (pat_high_r),
    .care_mask(care_mask_r),
    .used_len (used_len),
    .hit      (hit)
  );

  // Decision stage: count matches, take the wanted one, or close the region.
  // The fit test wraps at 32 bits, so a saturated position never fits.
  always_comb begin
    done_eff     = s1_first_r ? 1'b0 : done_r;
    cnt_eff      = s1_first_r ? '0 : cnt_r;
    fits         = (pos_r + 32'd1) >= 32'(used_len);
    cnt_nxt      = cnt_r;
    done_nxt     = done_r;
    produce      = 1'b0;
    out_data_nxt = out_data_r;
    if (s1_adv) begin
      cnt_nxt  = cnt_eff;
      done_nxt = done_eff;
      if (!done_eff) begin
        if (fits && hit && (cnt_eff == wanted_r)) begin
          done_nxt                  = 1'b1;
          produce                   = 1'b1;
          out_data_nxt.match_found  = 1'b1;
          out_data_nxt.match_offset = pos_r - (32'(used_len) - 32'd1);
        end else begin
          if (fits && hit && (cnt_eff != '1)) begin
            cnt_nxt = cnt_eff + 16'd1;
          end
          if (s1_last_r) begin
            done_nxt                  = 1'b1;
            produce                   = 1'b1;
            out_data_nxt.match_found  = 1'b0;
            out_data_nxt.match_offset = '0;
          end
        end
      end
    end
    out_valid_nxt = produce ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A region that already gave its result stays silent until a region start.
  a_silent_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    (produce && done_r) |-> s1_first_r)
    else $error("result produced for a region already closed");

  // A new result is only loaded from a word leaving the input stage.
  a_result_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    produce |-> (s1_valid_r && (!out_valid_r || out_ready)))
    else $error("result produced without an advancing word or overwrote one");

  // Back pressure reaches the input only with both stages occupied.
  a_ready_low_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("in_ready low with room in the pipeline");

  // A not-found result always carries offset zero.
  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.match_found) |-> (out_data_r.match_offset == '0))
    else $error("not-found result with nonzero offset");

endmodule

// File: rtl/mbps_window_cmp.sv
// Masked compare of the byte window against the configured pattern.
// Depends on mbps_pkg; instantiated by masked_byte_pattern_search.
module mbps_window_cmp import mbps_pkg::*; #(
  parameter int PATTERN_BYTES = PATTERN_BYTES_DEF,
  localparam int LW = $clog2(PATTERN_BYTES + 1),
  localparam int IW = $clog2(PATTERN_BYTES)
) (
  input  logic [PATTERN_BYTES-1:0][7:0] window,    // newest byte at index 0
  input  logic [63:0]                   pat_low,
  input  logic [63:0]                   pat_high,
  input  logic [15:0]                   care_mask,
  input  logic [LW-1:0]                 used_len,  // 1 .. PATTERN_BYTES
  output logic                          hit
);

  logic [127:0]                   pat_all;
  logic [PATTERN_BYTES-1:0]       miss;
  logic [PATTERN_BYTES-1:0][LW-1:0] pos;

  assign pat_all = {pat_high, pat_low};

  // Pattern byte j lines up with the byte received len-1-j items ago.
  always_comb begin
    for (int j = 0; j < PATTERN_BYTES; j++) begin
      pos[j]  = used_len - LW'(1) - LW'(j);
      miss[j] = (LW'(j) < used_len) && ((j == 0) || care_mask[j]) &&
                (window[pos[j][IW-1:0]] != pat_all[8*j +: 8]);
    end
  end

  assign hit = ~|miss;

endmodule
